FILE: rtl/nrmc_pkg.sv
// Package for the RMC field extractor: character codes, slot codes and digit weights.
package nrmc_pkg;

  // Default for the line limit LINE_MAX; a line holds at most LINE_MAX-1 bytes.
  localparam int LINE_MAX_DEF = 100;

  // Magnitudes are held in units of 1e-6 and saturate at 2^47-1.
  localparam int MAG_W = 47;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // Field widths: output values, quotient by 100, remainder by 100,
  // speed value and its remainder by 1000.
  localparam int VAL_W = 48;
  localparam int QUO_W = 41;
  localparam int REM_W = 7;
  localparam int SPD_REM_W = 10;
  localparam logic [QUO_W-1:0] QUO_SAT = QUO_W'(MAG_MAX / 100);
  localparam logic [REM_W-1:0] REM_SAT = REM_W'(MAG_MAX % 100);

  // Fraction digits kept.
  localparam logic [2:0] FRAC_DIGITS = 3'd6;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;

  // The tag "$GPRMC" is six characters long.
  localparam logic [2:0] TAG_LAST = 3'd5;

  // Slots of the held values.
  localparam logic [1:0] SLOT_LAT  = 2'd0;
  localparam logic [1:0] SLOT_LON  = 2'd1;
  localparam logic [1:0] SLOT_SPD  = 2'd2;
  localparam logic [1:0] SLOT_NONE = 2'd3;
  localparam int NUM_SLOTS = 3;

  // Characters of the tag.
  function automatic logic [7:0] tag_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_DOLLAR;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4D;
      3'd5:    ch = 8'h43;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // Whitespace skipped ahead of a number.
  function automatic logic is_space(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL) ||
           (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
  endfunction

  // Token index to value slot.
  function automatic logic [1:0] slot_of(input logic [3:0] tok);
    logic [1:0] s;
    case (tok)
      4'd3:    s = SLOT_LAT;
      4'd5:    s = SLOT_LON;
      4'd7:    s = SLOT_SPD;
      default: s = SLOT_NONE;
    endcase
    return s;
  endfunction

  // Weight of a fraction digit in units of 1e-6.
  function automatic logic [16:0] frac_acc_w(input logic [2:0] fc);
    logic [16:0] w;
    case (fc)
      3'd0:    w = 17'd100000;
      3'd1:    w = 17'd10000;
      3'd2:    w = 17'd1000;
      3'd3:    w = 17'd100;
      3'd4:    w = 17'd10;
      3'd5:    w = 17'd1;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

  // The same weight split into its quotient by 100 ...
  function automatic logic [9:0] frac_quo_w(input logic [2:0] fc);
    logic [9:0] w;
    case (fc)
      3'd0:    w = 10'd1000;
      3'd1:    w = 10'd100;
      3'd2:    w = 10'd10;
      3'd3:    w = 10'd1;
      default: w = 10'd0;
    endcase
    return w;
  endfunction

  // ... and its remainder by 100.
  function automatic logic [3:0] frac_rem_w(input logic [2:0] fc);
    logic [3:0] w;
    case (fc)
      3'd4:    w = 4'd10;
      3'd5:    w = 4'd1;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  // Weight times 1.852: whole part ...
  function automatic logic [17:0] frac_spd_w(input logic [2:0] fc);
    logic [17:0] w;
    case (fc)
      3'd0:    w = 18'd185200;
      3'd1:    w = 18'd18520;
      3'd2:    w = 18'd1852;
      3'd3:    w = 18'd185;
      3'd4:    w = 18'd18;
      3'd5:    w = 18'd1;
      default: w = 18'd0;
    endcase
    return w;
  endfunction

  // ... and thousandths.
  function automatic logic [9:0] frac_spd_rem_w(input logic [2:0] fc);
    logic [9:0] w;
    case (fc)
      3'd3:    w = 10'd200;
      3'd4:    w = 10'd520;
      3'd5:    w = 10'd852;
      default: w = 10'd0;
    endcase
    return w;
  endfunction

  // Quotient by 10 of a value below 100, by parallel compares.
  function automatic logic [3:0] div10_small(input logic [6:0] x);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (x >= 7'(10 * k)) n = n + 4'd1;
    end
    return n;
  endfunction

  // Quotient by 1000 of a value below 10000, by parallel compares.
  function automatic logic [3:0] div1000_small(input logic [13:0] x);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (x >= 14'(1000 * k)) n = n + 4'd1;
    end
    return n;
  endfunction

endpackage

FILE: rtl/nmea_rmc_field_extractor.sv
// Top level of the RMC field extractor: byte parser, token close and held values.
//
// Receives one character per beat on rx_byte (rx_valid / rx_ready). Bytes form
// lines that end at a newline or after LINE_MAX-1 bytes. Every line end gives
// one result beat (result_valid / result_ready): sentence_matched tells whether
// the line carried the "$GPRMC" tag, and the three held values (latitude and
// longitude over 100, speed in km/h, all in units of 1e-6) are updated from
// tokens 3, 5 and 7 of a tagged line before they are shown.
// Throughput is one byte per cycle while no line end stalls. Each byte is
// parsed in the cycle it is taken; closing a token and committing a line
// happen in a second register stage, which feeds the result register.
// The value arithmetic is incremental: the quotient by 100 and the speed
// scaled by 1.852 are kept alongside the magnitude, one digit per byte.
// While a result waits on result_ready, the next line end stalls in the
// second stage and rx_ready drops until the result is taken; bytes keep
// flowing until that line end reaches the second stage.
// Reset clears the parser, the held values and the result register.
module nmea_rmc_field_extractor #(
  parameter int LINE_MAX = nrmc_pkg::LINE_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rx_valid,
  output logic                              rx_ready,
  input  logic [7:0]                        rx_byte,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              sentence_matched,
  output logic signed [nrmc_pkg::VAL_W-1:0] latitude_micro,
  output logic signed [nrmc_pkg::VAL_W-1:0] longitude_micro,
  output logic signed [nrmc_pkg::VAL_W-1:0] speed_micro_kmh
);
  import nrmc_pkg::*;

  localparam int LC_W = $clog2(LINE_MAX);
  localparam int QX_W = QUO_W + 4;
  localparam int WIDE_W = VAL_W + 4;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGNED,
    PH_INT,
    PH_FRAC,
    PH_DONE
  } phase_t;

  // Line and token state.
  logic [LC_W-1:0] line_count, line_count_next;
  logic [2:0]      tag_progress, tag_progress_next;
  logic            tag_seen, tag_seen_next;
  logic            zero_seen, zero_seen_next;
  logic [3:0]      token_number, token_number_next;
  logic            inside_token, inside_token_next;

  // Number reader state.
  phase_t                 phase, phase_next;
  logic                   negative, negative_next;
  logic [MAG_W-1:0]       acc, acc_next;
  logic [2:0]             frac_count, frac_count_next;
  logic [QUO_W-1:0]       quot, quot_next;
  logic [REM_W-1:0]       rem, rem_next;
  logic [VAL_W-1:0]       speed, speed_next;
  logic [SPD_REM_W-1:0]   speed_rem, speed_rem_next;

  // Second stage: pending close and line end.
  logic       dc_valid, dc_valid_next;
  logic [1:0] dc_slot, dc_slot_next;
  logic       le_valid, le_valid_next;
  logic       le_tag, le_tag_next;

  logic [VAL_W-1:0]        pending [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]    pending_valid;
  logic signed [VAL_W-1:0] held [NUM_SLOTS];

  logic accept;
  logic stall;
  logic le_fire;

  // Byte decode.
  logic [3:0] digit;
  logic       is_digit;
  logic [1:0] cur_slot;

  // Base values of the reader, zeroed at the start of a token.
  phase_t               b_phase;
  logic                 b_negative;
  logic [MAG_W-1:0]     b_acc;
  logic [2:0]           b_frac_count;
  logic [QUO_W-1:0]     b_quot;
  logic [REM_W-1:0]     b_rem;
  logic [VAL_W-1:0]     b_speed;
  logic [SPD_REM_W-1:0] b_speed_rem;

  // Reader results for this byte.
  phase_t               f_phase;
  logic                 f_negative;
  logic [MAG_W-1:0]     f_acc;
  logic [2:0]           f_frac_count;
  logic [QUO_W-1:0]     f_quot;
  logic [REM_W-1:0]     f_rem;
  logic [VAL_W-1:0]     f_speed;
  logic [SPD_REM_W-1:0] f_speed_rem;

  // Digit step terms.
  logic [WIDE_W-1:0]    v_int, v_frac;
  logic [3:0]           r_div;
  logic [REM_W-1:0]     r_low;
  logic [13:0]          t10;
  logic [3:0]           t10_div;
  logic [7:0]           r_sum;
  logic                 r_carry;
  logic [13:0]          t_sum;
  logic [3:0]           t_carry;
  logic                 lead_num;
  logic                 do_int, do_frac;

  // Closed value.
  logic [VAL_W-1:0] spd_clamped;
  logic [VAL_W-1:0] closed_mag;
  logic [VAL_W-1:0] closed_val;

  assign accept   = rx_valid && rx_ready;
  assign stall    = le_valid && result_valid && !result_ready;
  assign rx_ready = !stall;
  assign le_fire  = le_valid && !stall;

  assign is_digit = (rx_byte >= CH_DIG0) && (rx_byte <= CH_DIG9);
  assign digit    = is_digit ? rx_byte[3:0] : 4'd0;
  assign cur_slot = slot_of(token_number);

  // A new token starts from a cleared reader.
  always_comb begin
    if (inside_token) begin
      b_phase      = phase;
      b_negative   = negative;
      b_acc        = acc;
      b_frac_count = frac_count;
      b_quot       = quot;
      b_rem        = rem;
      b_speed      = speed;
      b_speed_rem  = speed_rem;
    end else begin
      b_phase      = PH_LEAD;
      b_negative   = 1'b0;
      b_acc        = '0;
      b_frac_count = '0;
      b_quot       = '0;
      b_rem        = '0;
      b_speed      = '0;
      b_speed_rem  = '0;
    end
  end

  // Integer and fraction digit steps, each on the base values.
  always_comb begin
    v_int   = WIDE_W'(b_acc) * WIDE_W'(10) + WIDE_W'(digit) * WIDE_W'(1000000);
    r_div   = div10_small(b_rem);
    r_low   = b_rem - REM_W'(r_div) * REM_W'(10);
    t10     = 14'(b_speed_rem) * 14'd10;
    t10_div = div1000_small(t10);

    v_frac  = WIDE_W'(b_acc) + WIDE_W'(digit) * WIDE_W'(frac_acc_w(b_frac_count));
    r_sum   = 8'(b_rem) + 8'(digit) * 8'(frac_rem_w(b_frac_count));
    r_carry = (r_sum >= 8'd100);
    t_sum   = 14'(b_speed_rem) + 14'(digit) * 14'(frac_spd_rem_w(b_frac_count));
    t_carry = div1000_small(t_sum);
  end

  // Decimal reader: sign, integer digits, point, fraction digits.
  always_comb begin
    f_phase      = b_phase;
    f_negative   = b_negative;
    f_acc        = b_acc;
    f_frac_count = b_frac_count;
    f_quot       = b_quot;
    f_rem        = b_rem;
    f_speed      = b_speed;
    f_speed_rem  = b_speed_rem;
    lead_num     = 1'b0;
    do_int       = 1'b0;
    do_frac      = 1'b0;

    case (b_phase)
      PH_LEAD: begin
        if (is_space(rx_byte)) begin
          lead_num = 1'b0;
        end else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)) begin
          f_negative = (rx_byte == CH_MINUS);
          f_phase    = PH_SIGNED;
        end else begin
          lead_num = 1'b1;
        end
      end
      PH_SIGNED, PH_INT: begin
        lead_num = 1'b1;
      end
      PH_FRAC: begin
        if (is_digit) begin
          do_frac = (b_frac_count < FRAC_DIGITS);
        end else begin
          f_phase = PH_DONE;
        end
      end
      default: begin
        lead_num = 1'b0;
      end
    endcase

    if (lead_num) begin
      if (is_digit) begin
        do_int  = 1'b1;
        f_phase = PH_INT;
      end else if (rx_byte == CH_DOT) begin
        f_phase = PH_FRAC;
      end else begin
        f_phase = PH_DONE;
      end
    end

    // Integer digit: everything times ten plus the digit, saturating on overflow.
    if (do_int) begin
      if (v_int > WIDE_W'(MAG_MAX)) begin
        f_acc       = MAG_MAX;
        f_quot      = QUO_SAT;
        f_rem       = REM_SAT;
        f_speed     = VAL_W'(MAG_MAX);
        f_speed_rem = '0;
      end else begin
        f_acc       = MAG_W'(v_int);
        f_quot      = QUO_W'(QX_W'(b_quot) * QX_W'(10) + QX_W'(digit) * QX_W'(10000) +
                             QX_W'(r_div));
        f_rem       = REM_W'(r_low * REM_W'(10));
        f_speed     = VAL_W'(WIDE_W'(b_speed) * WIDE_W'(10) +
                             WIDE_W'(digit) * WIDE_W'(1852000) + WIDE_W'(t10_div));
        f_speed_rem = SPD_REM_W'(t10 - 14'(t10_div) * 14'd1000);
      end
    end

    // Fraction digit: add its weight, carry the remainders, saturating on overflow.
    if (do_frac) begin
      f_frac_count = b_frac_count + 3'd1;
      if (v_frac > WIDE_W'(MAG_MAX)) begin
        f_acc       = MAG_MAX;
        f_quot      = QUO_SAT;
        f_rem       = REM_SAT;
        f_speed     = VAL_W'(MAG_MAX);
        f_speed_rem = '0;
      end else begin
        f_acc       = MAG_W'(v_frac);
        f_quot      = b_quot + QUO_W'(digit) * QUO_W'(frac_quo_w(b_frac_count)) +
                      QUO_W'(r_carry);
        f_rem       = r_carry ? REM_W'(r_sum - 8'd100) : REM_W'(r_sum);
        f_speed     = b_speed + VAL_W'(digit) * VAL_W'(frac_spd_w(b_frac_count)) +
                      VAL_W'(t_carry);
        f_speed_rem = SPD_REM_W'(t_sum - 14'(t_carry) * 14'd1000);
      end
    end
  end

  // Line, tag and token control for the accepted byte.
  always_comb begin
    logic close_now;
    logic line_end;
    logic in_tok;
    logic tag_now;

    line_count_next   = line_count;
    tag_progress_next = tag_progress;
    tag_seen_next     = tag_seen;
    zero_seen_next    = zero_seen;
    token_number_next = token_number;
    inside_token_next = inside_token;
    phase_next        = phase;
    negative_next     = negative;
    acc_next          = acc;
    frac_count_next   = frac_count;
    quot_next         = quot;
    rem_next          = rem;
    speed_next        = speed;
    speed_rem_next    = speed_rem;
    close_now         = 1'b0;
    line_end          = 1'b0;
    in_tok            = inside_token;
    tag_now           = tag_seen;

    if (accept) begin
      line_end        = (rx_byte == CH_NL) || (line_count == LC_W'(LINE_MAX - 2));
      line_count_next = line_count + LC_W'(1);

      if (!zero_seen) begin
        if (rx_byte == CH_NUL) begin
          zero_seen_next = 1'b1;
          close_now      = inside_token;
          in_tok         = 1'b0;
        end else begin
          // Tag search.
          if (rx_byte == tag_char(tag_progress)) begin
            if (tag_progress == TAG_LAST) begin
              tag_now           = 1'b1;
              tag_progress_next = 3'd0;
            end else begin
              tag_progress_next = tag_progress + 3'd1;
            end
          end else begin
            tag_progress_next = (rx_byte == CH_DOLLAR) ? 3'd1 : 3'd0;
          end

          if (rx_byte == CH_COMMA) begin
            close_now = inside_token;
            in_tok    = 1'b0;
          end else begin
            in_tok = 1'b1;
            if (cur_slot != SLOT_NONE) begin
              phase_next      = f_phase;
              negative_next   = f_negative;
              acc_next        = f_acc;
              frac_count_next = f_frac_count;
              quot_next       = f_quot;
              rem_next        = f_rem;
              speed_next      = f_speed;
              speed_rem_next  = f_speed_rem;
            end else if (!inside_token) begin
              phase_next      = PH_LEAD;
              negative_next   = 1'b0;
            end
          end
        end
      end

      // A line end closes an open token.
      if (line_end && in_tok) begin
        close_now = 1'b1;
      end
      inside_token_next = in_tok && !close_now;
      tag_seen_next     = tag_now;
      if (close_now && (token_number != 4'hF)) begin
        token_number_next = token_number + 4'd1;
      end

      if (line_end) begin
        line_count_next   = '0;
        tag_progress_next = 3'd0;
        tag_seen_next     = 1'b0;
        zero_seen_next    = 1'b0;
        token_number_next = 4'd0;
        inside_token_next = 1'b0;
      end
    end

    dc_valid_next = close_now && (cur_slot != SLOT_NONE);
    dc_slot_next  = cur_slot;
    le_valid_next = line_end;
    le_tag_next   = tag_now;
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= '0;
      tag_progress <= 3'd0;
      tag_seen     <= 1'b0;
      zero_seen    <= 1'b0;
      token_number <= 4'd0;
      inside_token <= 1'b0;
      phase        <= PH_LEAD;
      negative     <= 1'b0;
      acc          <= '0;
      frac_count   <= '0;
      quot         <= '0;
      rem          <= '0;
      speed        <= '0;
      speed_rem    <= '0;
      dc_valid     <= 1'b0;
      dc_slot      <= SLOT_NONE;
      le_valid     <= 1'b0;
      le_tag       <= 1'b0;
    end else begin
      line_count   <= line_count_next;
      tag_progress <= tag_progress_next;
      tag_seen     <= tag_seen_next;
      zero_seen    <= zero_seen_next;
      token_number <= token_number_next;
      inside_token <= inside_token_next;
      phase        <= phase_next;
      negative     <= negative_next;
      acc          <= acc_next;
      frac_count   <= frac_count_next;
      quot         <= quot_next;
      rem          <= rem_next;
      speed        <= speed_next;
      speed_rem    <= speed_rem_next;
      if (!stall) begin
        dc_valid <= dc_valid_next;
        dc_slot  <= dc_slot_next;
        le_valid <= le_valid_next;
        le_tag   <= le_tag_next;
      end
    end
  end

  // Signed value of the token that closed in the previous beat.
  always_comb begin
    spd_clamped = (speed > VAL_W'(MAG_MAX)) ? VAL_W'(MAG_MAX) : speed;
    closed_mag  = (dc_slot == SLOT_SPD) ? spd_clamped : VAL_W'(quot);
    closed_val  = negative ? (VAL_W'(0) - closed_mag) : closed_mag;
  end

  // Pending values of the current line.
  always_ff @(posedge clk) begin
    if (!stall && dc_valid && !le_valid) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (dc_slot == 2'(i)) pending[i] <= closed_val;
      end
    end
  end

  // Commit at line end and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid    <= '0;
      result_valid     <= 1'b0;
      sentence_matched <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) held[i] <= '0;
    end else begin
      if (result_valid && result_ready) result_valid <= 1'b0;
      if (le_fire) begin
        if (le_tag) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (dc_valid && (dc_slot == 2'(i))) begin
              held[i] <= $signed(closed_val);
            end else if (pending_valid[i]) begin
              held[i] <= $signed(pending[i]);
            end
          end
        end
        pending_valid    <= '0;
        sentence_matched <= le_tag;
        result_valid     <= 1'b1;
      end else if (!stall && dc_valid) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (dc_slot == 2'(i)) pending_valid[i] <= 1'b1;
        end
      end
    end
  end

  assign latitude_micro  = held[SLOT_LAT];
  assign longitude_micro = held[SLOT_LON];
  assign speed_micro_kmh = held[SLOT_SPD];

  // The line counter clears before it reaches the line limit.
  a_line_count_range: assert property (@(posedge clk) disable iff (rst)
    line_count <= LC_W'(LINE_MAX - 2))
    else $error("line counter past the line limit");

  // The tag matcher never points past the last tag character.
  a_tag_range: assert property (@(posedge clk) disable iff (rst)
    tag_progress <= TAG_LAST)
    else $error("tag matcher out of range");

  // Incremental remainders stay below their divisors.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (rem < REM_W'(100)) && (speed_rem < SPD_REM_W'(1000)))
    else $error("digit remainder out of range");

  // Only a value slot is ever scheduled for a close.
  a_dc_slot: assert property (@(posedge clk) disable iff (rst)
    dc_valid |-> (dc_slot != SLOT_NONE))
    else $error("close scheduled for a token without a slot");

  // Held values change only when a line end is committed.
  a_held_stable: assert property (@(posedge clk) disable iff (rst)
    !le_fire |=> $stable({held[SLOT_LAT], held[SLOT_LON], held[SLOT_SPD]}))
    else $error("held value changed outside a line end");

endmodule
